/* hdl/wbs_pkg.sv */
// Shared types and constants of the word break segmenter.
package wbs_pkg;

  // Default sizes of the dictionary.
  localparam int unsigned DictWordsDef  = 16;
  localparam int unsigned MaxWordLenDef = 16;

  // Fixed field widths.
  localparam int unsigned CmdW   = 2;
  localparam int unsigned SlotFw = 4;
  localparam int unsigned PosFw  = 4;
  localparam int unsigned LenW   = 5;
  localparam int unsigned CharW  = 8;

  // Input commands; the fourth code has no meaning and is dropped.
  typedef enum logic [CmdW-1:0] {
    CmdLoad = 2'd0,
    CmdText = 2'd1,
    CmdEnd  = 2'd2
  } cmd_e;

  // Tag that travels alongside a dictionary row read.
  typedef struct packed {
    logic vld;
    logic last;
    logic used;
  } rd_tag_t;

  // Per-slot outcome of the match pipeline.
  typedef struct packed {
    logic vld;
    logic last;
    logic hit;
  } match_res_t;

endpackage

/* hdl/wbs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module wbs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/wbs_match.sv */
// Two-stage pipeline that checks one dictionary row against the text history.
module wbs_match #(
  parameter int unsigned MaxWordLen = wbs_pkg::MaxWordLenDef
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  wbs_pkg::rd_tag_t                                      rd_tag_i,
  input  logic [wbs_pkg::LenW+wbs_pkg::CharW*MaxWordLen-1:0]    row_i,
  input  logic [wbs_pkg::CharW*MaxWordLen-1:0]                  hist_i,
  input  logic [MaxWordLen:0]                                   reach_i,
  output wbs_pkg::match_res_t                                   res_o
);
  import wbs_pkg::*;

  localparam int unsigned HistW     = CharW * MaxWordLen;
  localparam int unsigned ReachIdxW = $clog2(MaxWordLen + 1);
  localparam int unsigned ShW       = (MaxWordLen > 1) ? $clog2(MaxWordLen) : 1;
  localparam int unsigned CmpW      = 8;

  logic [LenW-1:0]       row_len;
  logic [HistW-1:0]      row_word;
  logic [LenW-1:0]       len_m1;
  logic                  len_ok;
  logic                  reach_hit;
  logic [CmpW-1:0]       shift_diff;
  logic [ShW-1:0]        shamt;
  logic [HistW-1:0]      hist_rev;
  logic [HistW-1:0]      aligned;
  logic [MaxWordLen-1:0] mask;

  logic                  s1_vld_q;
  logic                  s1_last_q;
  logic                  s1_ok_q;
  logic [MaxWordLen-1:0] s1_mask_q;
  logic [HistW-1:0]      s1_word_q;
  logic [HistW-1:0]      s1_hist_q;

  logic [MaxWordLen-1:0] lane_eq;
  match_res_t            res_d;
  match_res_t            res_q;

  // Stage one: align the history so that byte p faces word character p.
  always_comb begin
    row_len    = row_i[HistW +: LenW];
    row_word   = row_i[HistW-1:0];
    len_m1     = row_len - LenW'(1);
    len_ok     = (row_len != '0) && (CmpW'(row_len) <= CmpW'(MaxWordLen));
    reach_hit  = reach_i[ReachIdxW'(len_m1)];
    shift_diff = CmpW'(MaxWordLen) - CmpW'(row_len);
    shamt      = shift_diff[ShW-1:0];
    for (int j = 0; j < MaxWordLen; j++) begin
      hist_rev[CharW*j +: CharW] = hist_i[CharW*(MaxWordLen-1-j) +: CharW];
    end
    aligned = hist_rev >> {shamt, 3'b000};
    for (int p = 0; p < MaxWordLen; p++) begin
      mask[p] = CmpW'(p) < CmpW'(row_len);
    end
  end

  // Stage one control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= rd_tag_i.vld;
    end
  end

  // Stage one data registers.
  always_ff @(posedge clk_i) begin
    s1_last_q <= rd_tag_i.last;
    s1_ok_q   <= rd_tag_i.used & len_ok & reach_hit;
    s1_mask_q <= mask;
    s1_word_q <= row_word;
    s1_hist_q <= aligned;
  end

  // Stage two: compare the covered lanes.
  always_comb begin
    for (int p = 0; p < MaxWordLen; p++) begin
      lane_eq[p] = !s1_mask_q[p] ||
                   (s1_word_q[CharW*p +: CharW] == s1_hist_q[CharW*p +: CharW]);
    end
    res_d.vld  = s1_vld_q;
    res_d.last = s1_last_q;
    res_d.hit  = s1_ok_q & (&lane_eq);
  end

  // Stage two result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* hdl/word_break_segmenter.sv */
// Top level of the word break segmenter: command decode, scan sequencer, text state.
//
//   Channel | Direction | Handshake               | Payload
//   in      | input     | in_valid_i / in_ready_o  | cmd_i, word_slot_i, char_pos_i,
//           |           |                         | word_len_i, char_value_i
//   out     | output    | out_valid_o / out_ready_i | segmentable_o
//
// A load beat passes through accept, row read and merged row write.
// A text beat reads one dictionary row per cycle from the row memory,
// and the two-stage match pipeline then drains.
// An end beat is held off while the sequencer is busy and while an earlier result waits.
// Reset is asynchronous and active low; it marks all slots unused and needs no
// clearing pass. A stalled result does not block load or text beats.
module word_break_segmenter #(
  parameter int unsigned DictWords  = wbs_pkg::DictWordsDef,
  parameter int unsigned MaxWordLen = wbs_pkg::MaxWordLenDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [wbs_pkg::CmdW-1:0]    cmd_i,
  input  logic [wbs_pkg::SlotFw-1:0]  word_slot_i,
  input  logic [wbs_pkg::PosFw-1:0]   char_pos_i,
  input  logic [wbs_pkg::LenW-1:0]    word_len_i,
  input  logic [wbs_pkg::CharW-1:0]   char_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        segmentable_o
);
  import wbs_pkg::*;

  localparam int unsigned SlotW = (DictWords > 1) ? $clog2(DictWords) : 1;
  localparam int unsigned PosW  = (MaxWordLen > 1) ? $clog2(MaxWordLen) : 1;
  localparam int unsigned HistW = CharW * MaxWordLen;
  localparam int unsigned RowW  = LenW + HistW;
  localparam int unsigned SlotCmpW = 9;
  localparam int unsigned PosCmpW  = 7;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StLoadRd = 5'b00010,
    StLoadWr = 5'b00100,
    StScan   = 5'b01000,
    StDrain  = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [SlotW-1:0]    scan_q, scan_d;
  logic [DictWords-1:0] used_q, used_d;
  logic [MaxWordLen:0] reach_q, reach_d;
  logic                hit_q, hit_d;
  rd_tag_t             tag_q, tag_d;
  logic                out_valid_q, out_valid_d;
  logic                seg_q, seg_d;
  logic [HistW-1:0]    hist_q;

  logic [SlotW-1:0]    ld_slot_q;
  logic [PosW-1:0]     ld_pos_q;
  logic [LenW-1:0]     ld_len_q;
  logic [CharW-1:0]    ld_char_q;

  logic                in_acc;
  logic                load_ok;
  logic                scan_last;
  logic                ram_we;
  logic                ram_re;
  logic [SlotW-1:0]    ram_raddr;
  logic [RowW-1:0]     ram_rdata;
  logic [RowW-1:0]     merged_row;
  match_res_t          res;
  logic                hit_final;

  // Input handshake; beats wait for the idle state, an end beat also for a free result register.
  assign in_ready_o = (state_q == StIdle) &&
                      !((cmd_i == CmdEnd) && out_valid_q && !out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_ok    = (SlotCmpW'(word_slot_i) < SlotCmpW'(DictWords)) &&
                      (PosCmpW'(char_pos_i) < PosCmpW'(MaxWordLen));
  assign scan_last  = (scan_q == SlotW'(DictWords - 1));
  assign hit_final  = hit_q | (res.vld & res.hit);

  // Row memory: word length above the characters, character p in byte p.
  assign ram_re    = (state_q == StLoadRd) || (state_q == StScan);
  assign ram_raddr = (state_q == StLoadRd) ? ld_slot_q : scan_q;
  assign ram_we    = (state_q == StLoadWr);

  // Merge the loaded character and length into the row just read.
  always_comb begin
    merged_row = ram_rdata;
    merged_row[HistW +: LenW] = ld_len_q;
    for (int p = 0; p < MaxWordLen; p++) begin
      if (PosW'(p) == ld_pos_q) begin
        merged_row[CharW*p +: CharW] = ld_char_q;
      end
    end
  end

  wbs_ram #(
    .Width (RowW),
    .Depth (DictWords)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ld_slot_q),
    .wdata_i (merged_row),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  wbs_match #(
    .MaxWordLen (MaxWordLen)
  ) u_match (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_tag_i (tag_q),
    .row_i    (ram_rdata),
    .hist_i   (hist_q),
    .reach_i  (reach_q),
    .res_o    (res)
  );

  // Sequencer: loads read, merge and write back; text beats scan every slot; end beats present the result.
  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    used_d      = used_q;
    reach_d     = reach_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && !out_ready_i;
    seg_d       = seg_q;
    tag_d.vld   = (state_q == StScan);
    tag_d.last  = scan_last;
    tag_d.used  = used_q[scan_q];
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          unique case (cmd_i)
            CmdLoad: begin
              if (load_ok) begin
                state_d = StLoadRd;
              end
            end
            CmdText: begin
              state_d = StScan;
              scan_d  = '0;
              hit_d   = 1'b0;
            end
            CmdEnd: begin
              out_valid_d = 1'b1;
              seg_d       = reach_q[0];
              reach_d     = (MaxWordLen + 1)'(1);
            end
            default: begin
            end
          endcase
        end
      end
      StLoadRd: begin
        state_d = StLoadWr;
      end
      StLoadWr: begin
        used_d[ld_slot_q] = 1'b1;
        state_d           = StIdle;
      end
      StScan: begin
        if (res.vld) begin
          hit_d = hit_final;
        end
        if (scan_last) begin
          state_d = StDrain;
        end else begin
          scan_d = scan_q + SlotW'(1);
        end
      end
      StDrain: begin
        if (res.vld) begin
          hit_d = hit_final;
          if (res.last) begin
            reach_d = {reach_q[MaxWordLen-1:0], hit_final};
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      scan_q      <= '0;
      used_q      <= '0;
      reach_q     <= (MaxWordLen + 1)'(1);
      hit_q       <= 1'b0;
      tag_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      used_q      <= used_d;
      reach_q     <= reach_d;
      hit_q       <= hit_d;
      tag_q       <= tag_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load fields, text history and the result bit.
  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
    if (in_acc && (cmd_i == CmdLoad)) begin
      ld_slot_q <= SlotW'(word_slot_i);
      ld_pos_q  <= PosW'(char_pos_i);
      ld_len_q  <= word_len_i;
      ld_char_q <= char_value_i;
    end
    if (in_acc && (cmd_i == CmdText)) begin
      hist_q <= (hist_q << CharW) | HistW'(char_value_i);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign segmentable_o = seg_q;

`ifndef SYNTHESIS
  // Match results only come back while a text beat is being scanned.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.vld |-> ((state_q == StScan) || (state_q == StDrain)))
    else $error("match result outside a scan");

  // The row write of a load always follows its own row read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLoadWr) |-> ($past(state_q) == StLoadRd))
    else $error("row write without preceding read");

  // The last slot result shifts the reach bits and ends the scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StDrain) && res.vld && res.last) |=>
      ((state_q == StIdle) && (reach_q[MaxWordLen] == $past(reach_q[MaxWordLen-1]))))
    else $error("scan did not finish cleanly");

  // An end beat presents a result and restarts the reach bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (cmd_i == CmdEnd)) |=>
      (out_valid_q && (reach_q == (MaxWordLen + 1)'(1))))
    else $error("end beat did not restart the text");
`endif

endmodule

/* sim/tb_top.sv */
// Self-checking testbench of the word break segmenter with a built-in reach-bit predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wbs_pkg::*;

  localparam int unsigned NumSlots     = DictWordsDef;
  localparam int unsigned WordMax      = MaxWordLenDef;
  localparam logic [CmdW-1:0] CmdIgnored = 2'd3;
  localparam int unsigned RandomBeats  = 460;
  localparam int unsigned MinAnswers   = 40;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 40;

  typedef enum int unsigned {
    RdyAlways,
    RdyCoin,
    RdyRare,
    RdyPeriodic
  } rdy_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [CmdW-1:0]    cmd_i;
  logic [SlotFw-1:0]  word_slot_i;
  logic [PosFw-1:0]   char_pos_i;
  logic [LenW-1:0]    word_len_i;
  logic [CharW-1:0]   char_value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               segmentable_o;

  // Predictor state: dictionary, text history and reach bits.
  logic [CharW-1:0]   dict_chars [NumSlots][WordMax];
  logic [LenW-1:0]    dict_lens [NumSlots];
  logic [CharW-1:0]   text_hist [WordMax];
  logic [WordMax:0]   reach_mask;
  logic               answer_q [$];
  logic               want_seg;

  // Copy of the dictionary kept by the stimulus side to build texts.
  logic [CharW-1:0]   gen_chars [NumSlots][WordMax];
  logic [LenW-1:0]    gen_lens [NumSlots];
  logic [CharW-1:0]   alphabet [$];

  int unsigned        beats_sent;
  int unsigned        answers_seen;
  int unsigned        err_count;
  int unsigned        burst_left;
  bit                 sender_smooth;
  bit                 hold_req;

  word_break_segmenter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .word_slot_i   (word_slot_i),
    .char_pos_i    (char_pos_i),
    .word_len_i    (word_len_i),
    .char_value_i  (char_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .segmentable_o (segmentable_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Update the predicted state for one accepted beat.
  function automatic void apply_beat(input logic [CmdW-1:0] cmd,
                                     input logic [SlotFw-1:0] slot,
                                     input logic [PosFw-1:0] pos,
                                     input logic [LenW-1:0] len,
                                     input logic [CharW-1:0] ch);
    logic hit;
    logic same;
    int unsigned wl;
    case (cmd)
      CmdLoad: begin
        if (slot < NumSlots && pos < WordMax) begin
          dict_chars[slot][pos] = ch;
          dict_lens[slot] = len;
        end
      end
      CmdText: begin
        for (int i = WordMax - 1; i > 0; i--) text_hist[i] = text_hist[i-1];
        text_hist[0] = ch;
        hit = 1'b0;
        // A word ends here if it matches the newest characters and its start was reachable.
        for (int s = 0; s < NumSlots; s++) begin
          wl = dict_lens[s];
          if (wl != 0 && wl <= WordMax && reach_mask[wl-1]) begin
            same = 1'b1;
            for (int i = 0; i < wl; i++) begin
              if (dict_chars[s][wl-1-i] != text_hist[i]) same = 1'b0;
            end
            if (same) hit = 1'b1;
          end
        end
        reach_mask = {reach_mask[WordMax-1:0], hit};
      end
      CmdEnd: begin
        answer_q.push_back(reach_mask[0]);
        reach_mask = 1;
      end
      default: begin
      end
    endcase
  endfunction

  task automatic note_failure(input string msg);
    err_count++;
    if (err_count <= 10) $display("[%0t] %s", $time, msg);
  endtask

  // Track accepted input beats and check every result beat against the oldest answer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        apply_beat(cmd_i, word_slot_i, char_pos_i, word_len_i, char_value_i);
      if (out_valid_o && out_ready_i) begin
        if (answer_q.size() == 0) begin
          note_failure($sformatf("unexpected result: segmentable %0b with no answer pending",
                                 segmentable_o));
        end else begin
          want_seg = answer_q.pop_front();
          answers_seen++;
          if (segmentable_o !== want_seg)
            note_failure($sformatf("segmentable mismatch: expected %0b, got %0b",
                                   want_seg, segmentable_o));
        end
      end
    end
  end

  // Result side: stall patterns that change over time, plus a long hold-off on request.
  initial begin
    rdy_mode_e mode;
    int unsigned left;
    out_ready_i = 1'b0;
    mode = RdyAlways;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = rdy_mode_e'($urandom_range(3, 0));
          left = $urandom_range(300, 50);
        end
        left--;
        case (mode)
          RdyAlways: out_ready_i = 1'b1;
          RdyCoin:   out_ready_i = 1'($urandom);
          RdyRare:   out_ready_i = ($urandom_range(3, 0) == 0);
          default:   out_ready_i = (left % 5) < 3;
        endcase
      end
    end
  end

  // Offer one beat and hold it until accepted; idle gaps come between bursts.
  task automatic send_beat(input logic [CmdW-1:0] cmd, input logic [SlotFw-1:0] slot,
                           input logic [PosFw-1:0] pos, input logic [LenW-1:0] len,
                           input logic [CharW-1:0] ch);
    int unsigned idle;
    @(negedge clk_i);
    in_valid_i   = 1'b1;
    cmd_i        = cmd;
    word_slot_i  = slot;
    char_pos_i   = pos;
    word_len_i   = len;
    char_value_i = ch;
    if (cmd == CmdLoad && slot < NumSlots && pos < WordMax) begin
      gen_chars[slot][pos] = ch;
      gen_lens[slot] = len;
    end
    if (cmd != CmdIgnored) beats_sent++;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(24, 1);
      idle = sender_smooth ? 0 : $urandom_range(12, 0);
      if (idle != 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (idle - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic send_text(input logic [CharW-1:0] ch);
    send_beat(CmdText, SlotFw'($urandom), PosFw'($urandom), LenW'($urandom), ch);
  endtask

  task automatic send_end();
    send_beat(CmdEnd, SlotFw'($urandom), PosFw'($urandom), LenW'($urandom), CharW'($urandom));
  endtask

  task automatic send_ignored();
    send_beat(CmdIgnored, SlotFw'($urandom), PosFw'($urandom), LenW'($urandom),
              CharW'($urandom));
  endtask

  // Lower valid and pause until every pending answer has been checked.
  task automatic wait_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [CharW-1:0] pick_char();
    if (alphabet.size() == 0) return CharW'($urandom);
    return alphabet[$urandom_range(alphabet.size() - 1, 0)];
  endfunction

  // Mostly short words, some long ones, a few overlong or unused slots.
  function automatic logic [LenW-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 60) return LenW'($urandom_range(3, 1));
    if (r < 80) return LenW'($urandom_range(8, 4));
    if (r < 88) return LenW'($urandom_range(WordMax, 9));
    if (r < 94) return LenW'($urandom_range(31, WordMax + 1));
    return '0;
  endfunction

  // Write a word into one slot; an unused slot needs only a single load beat.
  task automatic load_word(input logic [SlotFw-1:0] slot, input logic [LenW-1:0] len);
    int unsigned n;
    n = (len == 0) ? 1 : ((len > WordMax) ? WordMax : len);
    for (int p = 0; p < n; p++)
      send_beat(CmdLoad, slot, (len == 0) ? PosFw'($urandom) : PosFw'(p), len, pick_char());
  endtask

  // Empty text answers yes, and the unused command is dropped.
  task automatic test_empty_text();
    send_end();
    send_ignored();
    send_end();
    wait_results();
  endtask

  // Write every dictionary character once: slot 0 holds the longest word of all-ones
  // bytes, the last slot a one-character word of zero, the rest stay unused.
  task automatic test_dictionary_fill();
    logic [LenW-1:0] len;
    logic [CharW-1:0] ch;
    for (int s = 0; s < NumSlots; s++) begin
      for (int p = 0; p < WordMax; p++) begin
        len = (s == 0) ? LenW'(WordMax) : ((s == NumSlots - 1) ? LenW'(1) : '0);
        if (s == 0) ch = '1;
        else if (s == NumSlots - 1 && p == 0) ch = '0;
        else ch = CharW'($urandom);
        send_beat(CmdLoad, SlotFw'(s), PosFw'(p), len, ch);
      end
    end
  endtask

  // A text longer than the history window made of the longest and the shortest word.
  task automatic test_longest_and_shortest();
    repeat (WordMax) send_text('1);
    send_text('0);
    send_end();
    wait_results();
  endtask

  // An overlong length never matches; length zero takes the slot out of use.
  task automatic test_overlong_and_unused();
    send_beat(CmdLoad, SlotFw'(1), '0, '1, 8'h41);
    send_text(8'h41);
    send_end();
    send_beat(CmdLoad, SlotFw'(1), '0, LenW'(1), 8'h41);
    send_text(8'h41);
    send_end();
    send_beat(CmdLoad, SlotFw'(1), '0, '0, 8'h41);
    send_text(8'h41);
    send_end();
    wait_results();
  endtask

  // Results are held off for a long stretch while texts keep coming, so end beats
  // back up and stall the input; then the sender pauses until all answers are in.
  task automatic test_result_backpressure();
    wait_results();
    hold_req = 1'b1;
    repeat (8) begin
      repeat ($urandom_range(3, 1)) send_text($urandom_range(1, 0) ? 8'h00 : CharW'($urandom));
      send_end();
    end
    wait_results();
  endtask

  // Random dictionaries over small alphabets, texts built mostly from their words.
  task automatic test_random_segmentation();
    int unsigned start;
    int unsigned s;
    int unsigned used [$];
    logic [CharW-1:0] txt [$];
    start = beats_sent;
    while (beats_sent - start < RandomBeats || answers_seen < MinAnswers) begin
      alphabet.delete();
      if ($urandom_range(9, 0) != 0)
        repeat ($urandom_range(4, 2)) alphabet.push_back(CharW'($urandom));
      sender_smooth = ($urandom_range(3, 0) == 0);

      // Now and then retire the whole dictionary before loading new words.
      if ($urandom_range(7, 0) == 0)
        for (int i = 0; i < NumSlots; i++)
          send_beat(CmdLoad, SlotFw'(i), PosFw'($urandom), '0, CharW'($urandom));
      repeat ($urandom_range(5, 1)) load_word(SlotFw'($urandom), pick_len());

      used.delete();
      for (int i = 0; i < NumSlots; i++)
        if (gen_lens[i] != 0 && gen_lens[i] <= WordMax) used.push_back(i);

      repeat ($urandom_range(6, 1)) begin
        txt.delete();
        if (used.size() != 0 && $urandom_range(3, 0) != 0) begin
          repeat ($urandom_range(5, 0)) begin
            s = used[$urandom_range(used.size() - 1, 0)];
            for (int p = 0; p < gen_lens[s]; p++) txt.push_back(gen_chars[s][p]);
          end
        end else begin
          repeat ($urandom_range(12, 1)) txt.push_back(pick_char());
        end
        // Sprinkle stray characters, replaced characters and dropped commands.
        foreach (txt[i]) begin
          if ($urandom_range(49, 0) == 0) send_ignored();
          if ($urandom_range(29, 0) == 0) send_text(pick_char());
          send_text(($urandom_range(19, 0) == 0) ? pick_char() : txt[i]);
        end
        send_end();
      end
      if ($urandom_range(2, 0) == 0) wait_results();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cmd_i         = CmdLoad;
    word_slot_i   = '0;
    char_pos_i    = '0;
    word_len_i    = '0;
    char_value_i  = '0;
    hold_req      = 1'b0;
    sender_smooth = 1'b0;
    burst_left    = 0;
    beats_sent    = 0;
    answers_seen  = 0;
    err_count     = 0;
    reach_mask    = 1;
    for (int i = 0; i < NumSlots; i++) begin
      dict_lens[i] = '0;
      gen_lens[i]  = '0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_text();
    test_dictionary_fill();
    test_longest_and_shortest();
    test_overlong_and_unused();
    test_result_backpressure();
    test_random_segmentation();

    wait_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (err_count == 0 && answer_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
